FILE: sv/sawbc_pkg.sv
// ----------------------------------------------------------------------------
// sawbc_pkg
// Shared constants, codes and helper functions for the write-back cache core.
// ----------------------------------------------------------------------------
`default_nettype none
package sawbc_pkg;
  localparam int unsigned OffsetBits   = 5;
  localparam int unsigned IndexBits    = 6;
  localparam int unsigned Ways         = 2;
  localparam int unsigned WordsPerLine = 1 << (OffsetBits - 2);
  localparam int unsigned Sets         = 1 << IndexBits;
  localparam int unsigned TagShift     = OffsetBits + IndexBits;
  localparam int unsigned TagBits      = 32 - TagShift;
  localparam int unsigned WordBits     = OffsetBits - 2;
  localparam int unsigned WayBits      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned SlotBits     = WayBits + IndexBits;
  localparam int unsigned AddrBits     = SlotBits + WordBits;
  localparam int unsigned NumSlots     = 1 << SlotBits;
  localparam int unsigned CntBits      = WordBits + 1;

  // Request codes
  localparam logic [2:0] ReqRead     = 3'd0;
  localparam logic [2:0] ReqWrite    = 3'd1;
  localparam logic [2:0] ReqFill     = 3'd2;
  localparam logic [2:0] ReqFlush    = 3'd3;
  localparam logic [2:0] ReqInvSet   = 3'd4;
  localparam logic [2:0] ReqInvAll   = 3'd5;

  // Result kinds
  localparam logic [2:0] KindReadData = 3'd0;
  localparam logic [2:0] KindDone     = 3'd1;
  localparam logic [2:0] KindMemWrite = 3'd2;
  localparam logic [2:0] KindMemRead  = 3'd3;
  localparam logic [2:0] KindError    = 3'd4;

  // Access sizes
  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;
  localparam logic [1:0] SizeBad  = 2'd3;

  // Extract the lane selected by size and byte offset
  function automatic logic [31:0] lane_extract(input logic [31:0] word,
                                               input logic [1:0] offs,
                                               input logic [1:0] size);
    logic [31:0] v;
    begin
      v = word;
      case (size)
        SizeByte: v = (word >> {offs, 3'b000}) & 32'h0000_00ff;
        SizeHalf: v = (word >> {offs[1], 4'b0000}) & 32'h0000_ffff;
        default:  v = word;
      endcase
      return v;
    end
  endfunction

  // Merge store data into a word
  function automatic logic [31:0] lane_merge(input logic [31:0] word,
                                             input logic [31:0] wdata,
                                             input logic [1:0] offs,
                                             input logic [1:0] size);
    logic [31:0] mask;
    logic [31:0] sd;
    begin
      case (size)
        SizeByte: begin
          mask = 32'h0000_00ff << {offs, 3'b000};
          sd   = wdata << {offs, 3'b000};
        end
        SizeHalf: begin
          mask = 32'h0000_ffff << {offs[1], 4'b0000};
          sd   = wdata << {offs[1], 4'b0000};
        end
        default: begin
          mask = 32'hffff_ffff;
          sd   = wdata;
        end
      endcase
      return (word & ~mask) | (sd & mask);
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/sawbc_ram.sv
// ----------------------------------------------------------------------------
// sawbc_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sawbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write or read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: sv/set_assoc_writeback_cache_core.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_core
// Two-way write-back cache, virtually indexed and physically tagged.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; it is taken at that
// edge. Results come out one per cycle when result_valid_o is high; last_o
// marks the final result of the request. The receiver cannot stall.
// Tags sit in one RAM and line words in another, each with one port and a
// registered read; valid and dirty bits are flip-flops cleared at reset.
// A lookup reads and then compares the tag of each way in turn. A write
// miss answers with a mem_write; a read or write hit goes on to read the
// data word, and a write with a bad size ends in an error answer. A read
// miss first writes back each dirty way of the set, then sends the mem_read.
// Each fill_word writes one word; the final one replays the read, and a
// failed one ends the fill with an error. Flush writes back each dirty way
// of the named set; other control ops and error answers give one result.
// Reset clears valid/dirty bits, the victim pointer and any pending fill at
// once; no clearing pass is needed. busy is high from acceptance until the
// cycle in which last_o is shown; the next request may be taken at its end.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_writeback_cache_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [31:0] virt_addr_i,
  input  wire logic [31:0] phys_addr_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [5:0]  set_number_i,
  input  wire logic [31:0] fill_data_i,
  input  wire logic        fill_error_i,
  output logic             result_valid_o,
  output logic [2:0]       result_kind_o,
  output logic [31:0]      data_o,
  output logic [31:0]      mem_addr_o,
  output logic [1:0]       mem_size_o,
  output logic             last_o
);
  localparam int unsigned SB = sawbc_pkg::SlotBits;
  localparam int unsigned WB = sawbc_pkg::WayBits;
  localparam int unsigned IB = sawbc_pkg::IndexBits;
  localparam int unsigned OB = sawbc_pkg::OffsetBits;
  localparam int unsigned DB = sawbc_pkg::WordBits;
  localparam int unsigned TB = sawbc_pkg::TagBits;
  localparam int unsigned CB = sawbc_pkg::CntBits;
  localparam int unsigned NW = sawbc_pkg::Ways;

  // Sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StTagRd  = 4'd1;  // issue tag read for way_q
  localparam logic [3:0] StTagCmp = 4'd2;  // compare tag of way_q
  localparam logic [3:0] StDatRd  = 4'd3;  // issue data word read
  localparam logic [3:0] StDatUse = 4'd4;  // read or merge data word
  localparam logic [3:0] StWbTag  = 4'd5;  // read tag of a dirty way
  localparam logic [3:0] StWbTagW = 4'd6;  // latch tag for write-back
  localparam logic [3:0] StWbWord = 4'd7;  // stream words of a dirty way
  localparam logic [3:0] StMiss   = 4'd8;  // allocate victim, send mem_read
  localparam logic [3:0] StFill   = 4'd9;  // write fill word
  localparam logic [3:0] StDone   = 4'd10; // one-result answer
  localparam logic [3:0] StWbNext = 4'd11; // pick next dirty way

  logic [3:0]  state_q, state_d;
  logic [2:0]  req_q;
  logic [31:0] virt_q, phys_q, wdata_q;
  logic [1:0]  size_q;
  logic [IB-1:0] set_q;
  logic [31:0] fdata_q;
  logic        ferr_q;
  logic [2:0]  dkind_q, dkind_d;
  logic        flush_op_q, flush_op_d;

  logic [WB-1:0] way_q, way_d;
  logic          hit_q, hit_d;
  logic [WB-1:0] hway_q, hway_d;
  logic [CB-1:0] wcnt_q, wcnt_d;
  logic [TB-1:0] wbtag_q, wbtag_d;

  logic [sawbc_pkg::NumSlots-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [WB-1:0] victim_q, victim_d;
  logic          fpend_q, fpend_d;
  logic [CB-1:0] fcnt_q, fcnt_d;
  logic [31:0]   pvirt_q, pvirt_d, pphys_q, pphys_d;
  logic [1:0]    psize_q, psize_d;

  // RAM ports
  logic                     tag_we;
  logic [SB-1:0]            tag_addr;
  logic [TB-1:0]            tag_wdata, tag_rdata;
  logic                     dat_we;
  logic [sawbc_pkg::AddrBits-1:0] dat_addr;
  logic [31:0]              dat_wdata, dat_rdata;

  // Result register
  logic        rv_d, rl_d;
  logic [2:0]  rk_d;
  logic [31:0] rdat_d, radr_d;
  logic [1:0]  rsz_d;

  sawbc_ram #(.Width(TB), .Depth(sawbc_pkg::NumSlots)) u_tag_ram (
    .clk_i(clk_i), .we_i(tag_we), .addr_i(tag_addr),
    .wdata_i(tag_wdata), .rdata_o(tag_rdata)
  );

  sawbc_ram #(.Width(32), .Depth(1 << sawbc_pkg::AddrBits)) u_dat_ram (
    .clk_i(clk_i), .we_i(dat_we), .addr_i(dat_addr),
    .wdata_i(dat_wdata), .rdata_o(dat_rdata)
  );

  logic [IB-1:0] vset, pset;
  logic [DB-1:0] vword;
  logic [TB-1:0] ptag;
  logic [SB-1:0] cur_slot, vic_slot;
  logic [WB-1:0] way_inc;
  logic          way_last;
  logic [31:0]   line_base;
  logic [31:0]   wb_base;
  logic          dirty_cur;

  assign vset      = virt_q[OB +: IB];
  assign vword     = virt_q[2 +: DB];
  assign pset      = pvirt_q[OB +: IB];
  assign ptag      = phys_q[sawbc_pkg::TagShift +: TB];
  assign cur_slot  = {way_q, set_q};
  assign vic_slot  = {victim_q, pset};
  assign way_last  = (32'(way_q) == NW - 1);
  assign way_inc   = way_last ? '0 : WB'(32'(way_q) + 1);
  assign line_base = {pphys_q[31:OB], {OB{1'b0}}};
  assign wb_base   = {wbtag_q, set_q, {OB{1'b0}}};
  assign dirty_cur = dirty_q[cur_slot];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    way_d      = way_q;
    hit_d      = hit_q;
    hway_d     = hway_q;
    wcnt_d     = wcnt_q;
    wbtag_d    = wbtag_q;
    dkind_d    = dkind_q;
    flush_op_d = flush_op_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    victim_d   = victim_q;
    fpend_d    = fpend_q;
    fcnt_d     = fcnt_q;
    pvirt_d    = pvirt_q;
    pphys_d    = pphys_q;
    psize_d    = psize_q;
    tag_we     = 1'b0;
    tag_addr   = cur_slot;
    tag_wdata  = ptag;
    dat_we     = 1'b0;
    dat_addr   = {hway_q, set_q, vword};
    dat_wdata  = wdata_q;
    rv_d       = 1'b0;
    rl_d       = 1'b0;
    rk_d       = sawbc_pkg::KindDone;
    rdat_d     = '0;
    radr_d     = '0;
    rsz_d      = '0;

    unique case (state_q)
      StIdle: begin
        way_d = '0;
        hit_d = 1'b0;
        wcnt_d = '0;
        flush_op_d = 1'b0;
        if (start) begin
          dkind_d = sawbc_pkg::KindDone;
          if (fpend_q && req_type_i != sawbc_pkg::ReqFill) begin
            dkind_d = sawbc_pkg::KindError;
            state_d = StDone;
          end else begin
            case (req_type_i) inside
              sawbc_pkg::ReqRead, sawbc_pkg::ReqWrite: state_d = StTagRd;
              sawbc_pkg::ReqFill: begin
                if (fpend_q) begin
                  state_d = StFill;
                end else begin
                  dkind_d = sawbc_pkg::KindError;
                  state_d = StDone;
                end
              end
              sawbc_pkg::ReqFlush: begin
                flush_op_d = 1'b1;
                state_d = StWbNext;
              end
              sawbc_pkg::ReqInvSet, sawbc_pkg::ReqInvAll: state_d = StDone;
              default: begin
                dkind_d = sawbc_pkg::KindError;
                state_d = StDone;
              end
            endcase
          end
        end
      end
      StTagRd: begin
        tag_addr = cur_slot;
        state_d  = StTagCmp;
      end
      StTagCmp: begin
        if (!hit_q && valid_q[cur_slot] && tag_rdata == ptag) begin
          hit_d  = 1'b1;
          hway_d = way_q;
        end
        if (way_last) begin
          way_d = '0;
          if (req_q == sawbc_pkg::ReqWrite) begin
            if (size_q == sawbc_pkg::SizeBad) begin
              dkind_d = sawbc_pkg::KindError;
              state_d = StDone;
            end else if (hit_d) begin
              state_d = StDatRd;
            end else begin
              rv_d   = 1'b1;
              rl_d   = 1'b1;
              rk_d   = sawbc_pkg::KindMemWrite;
              rdat_d = sawbc_pkg::lane_extract(wdata_q, 2'b00, size_q);
              radr_d = phys_q;
              rsz_d  = size_q;
              state_d = StIdle;
            end
          end else if (hit_d) begin
            state_d = StDatRd;
          end else begin
            state_d = StWbNext;
          end
        end else begin
          way_d   = way_inc;
          state_d = StTagRd;
        end
      end
      StDatRd: begin
        dat_addr = {hway_q, set_q, vword};
        state_d  = StDatUse;
      end
      StDatUse: begin
        dat_addr = {hway_q, set_q, vword};
        rv_d = 1'b1;
        rl_d = 1'b1;
        state_d = StIdle;
        if (req_q == sawbc_pkg::ReqWrite) begin
          dat_we    = 1'b1;
          dat_wdata = sawbc_pkg::lane_merge(dat_rdata, wdata_q, virt_q[1:0], size_q);
          dirty_d[{hway_q, set_q}] = 1'b1;
          victim_d = (32'(victim_q) == NW - 1) ? '0 : WB'(32'(victim_q) + 1);
          rk_d = sawbc_pkg::KindDone;
        end else if (size_q == sawbc_pkg::SizeBad) begin
          rk_d = sawbc_pkg::KindError;
        end else begin
          rk_d   = sawbc_pkg::KindReadData;
          rdat_d = sawbc_pkg::lane_extract(dat_rdata, virt_q[1:0], size_q);
          victim_d = (32'(victim_q) == NW - 1) ? '0 : WB'(32'(victim_q) + 1);
        end
      end
      StWbNext: begin
        // find next dirty way from way_q
        if (dirty_cur) begin
          state_d = StWbTag;
        end else if (way_last) begin
          way_d = '0;
          state_d = flush_op_q ? StDone : StMiss;
        end else begin
          way_d = way_inc;
        end
      end
      StWbTag: begin
        tag_addr = cur_slot;
        state_d  = StWbTagW;
      end
      StWbTagW: begin
        wbtag_d  = tag_rdata;
        wcnt_d   = '0;
        dat_addr = {way_q, set_q, {DB{1'b0}}};
        state_d  = StWbWord;
      end
      StWbWord: begin
        rv_d   = 1'b1;
        rk_d   = sawbc_pkg::KindMemWrite;
        rdat_d = dat_rdata;
        radr_d = wb_base + 32'({wcnt_q[DB-1:0], 2'b00});
        rsz_d  = sawbc_pkg::SizeWord;
        wcnt_d = CB'(32'(wcnt_q) + 1);
        dat_addr = {way_q, set_q, wcnt_d[DB-1:0]};
        if (32'(wcnt_d) == sawbc_pkg::WordsPerLine) begin
          dirty_d[cur_slot] = 1'b0;
          state_d = StWbNext;
        end
      end
      StMiss: begin
        tag_we    = 1'b1;
        tag_addr  = {victim_q, set_q};
        tag_wdata = ptag;
        valid_d[{victim_q, set_q}] = 1'b0;
        dirty_d[{victim_q, set_q}] = 1'b0;
        pvirt_d = virt_q;
        pphys_d = phys_q;
        psize_d = size_q;
        fpend_d = 1'b1;
        fcnt_d  = '0;
        rv_d   = 1'b1;
        rl_d   = 1'b1;
        rk_d   = sawbc_pkg::KindMemRead;
        radr_d = {phys_q[31:OB], {OB{1'b0}}};
        rsz_d  = sawbc_pkg::SizeWord;
        state_d = StIdle;
      end
      StFill: begin
        if (ferr_q) begin
          valid_d[vic_slot] = 1'b0;
          dirty_d[vic_slot] = 1'b0;
          fpend_d = 1'b0;
          fcnt_d  = '0;
          dkind_d = sawbc_pkg::KindError;
          state_d = StDone;
        end else begin
          dat_we    = 1'b1;
          dat_addr  = {victim_q, pset, fcnt_q[DB-1:0]};
          dat_wdata = fdata_q;
          fcnt_d    = CB'(32'(fcnt_q) + 1);
          if (32'(fcnt_d) == sawbc_pkg::WordsPerLine) begin
            fpend_d = 1'b0;
            fcnt_d  = '0;
            valid_d[vic_slot] = 1'b1;
            dirty_d[vic_slot] = 1'b0;
            // replay the read on the filled way
            hway_d = victim_q;
            state_d = StDatRd;
          end else begin
            rv_d   = 1'b1;
            rl_d   = 1'b1;
            rk_d   = sawbc_pkg::KindMemRead;
            radr_d = line_base + 32'({fcnt_d[DB-1:0], 2'b00});
            rsz_d  = sawbc_pkg::SizeWord;
            state_d = StIdle;
          end
        end
      end
      StDone: begin
        if (dkind_q == sawbc_pkg::KindDone) begin
          if (req_q == sawbc_pkg::ReqInvSet) begin
            for (int w = 0; w < NW; w++) begin
              valid_d[{WB'(w), set_q}] = 1'b0;
              dirty_d[{WB'(w), set_q}] = 1'b0;
            end
          end else if (req_q == sawbc_pkg::ReqInvAll) begin
            valid_d = '0;
            dirty_d = '0;
          end
        end
        rv_d = 1'b1;
        rl_d = 1'b1;
        rk_d = dkind_q;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Capture the request and set up the address used by later states
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q        <= req_type_i;
      virt_q       <= virt_addr_i;
      phys_q       <= phys_addr_i;
      size_q       <= access_size_i;
      wdata_q      <= write_data_i;
      fdata_q      <= fill_data_i;
      ferr_q       <= fill_error_i;
      if (req_type_i == sawbc_pkg::ReqFlush || req_type_i == sawbc_pkg::ReqInvSet) begin
        set_q <= IB'(set_number_i);
      end else if (req_type_i == sawbc_pkg::ReqFill) begin
        set_q <= pvirt_q[OB +: IB];
        virt_q <= pvirt_q;
        phys_q <= pphys_q;
        size_q <= psize_q;
      end else begin
        set_q <= virt_addr_i[OB +: IB];
      end
    end else if (state_q == StFill) begin
      virt_q <= pvirt_q;
    end
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      way_q          <= '0;
      hit_q          <= 1'b0;
      hway_q         <= '0;
      wcnt_q         <= '0;
      wbtag_q        <= '0;
      dkind_q        <= sawbc_pkg::KindDone;
      flush_op_q     <= 1'b0;
      valid_q        <= '0;
      dirty_q        <= '0;
      victim_q       <= '0;
      fpend_q        <= 1'b0;
      fcnt_q         <= '0;
      pvirt_q        <= '0;
      pphys_q        <= '0;
      psize_q        <= '0;
      result_valid_o <= 1'b0;
      last_o         <= 1'b0;
      result_kind_o  <= '0;
      data_o         <= '0;
      mem_addr_o     <= '0;
      mem_size_o     <= '0;
    end else begin
      state_q        <= state_d;
      way_q          <= way_d;
      hit_q          <= hit_d;
      hway_q         <= hway_d;
      wcnt_q         <= wcnt_d;
      wbtag_q        <= wbtag_d;
      dkind_q        <= dkind_d;
      flush_op_q     <= flush_op_d;
      valid_q        <= valid_d;
      dirty_q        <= dirty_d;
      victim_q       <= victim_d;
      fpend_q        <= fpend_d;
      fcnt_q         <= fcnt_d;
      pvirt_q        <= pvirt_d;
      pphys_q        <= pphys_d;
      psize_q        <= psize_d;
      result_valid_o <= rv_d;
      last_o         <= rl_d;
      result_kind_o  <= rk_d;
      data_o         <= rdat_d;
      mem_addr_o     <= radr_d;
      mem_size_o     <= rsz_d;
    end
  end

  // Busy until the final result has been shown
  assign busy = (state_q != StIdle) || (result_valid_o && !last_o);

`ifndef SYNTHESIS
  // last only ever marks a shown result
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without result");
  // a final result returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> (state_q == StIdle)) else $error("not idle after last");
  // no request is taken while a fill word is being written
  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> busy) else $error("accepting during fill");
  // a mem_read leaves a fill outstanding
  a_memrd_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == sawbc_pkg::KindMemRead) |-> fpend_q)
    else $error("mem_read without fill");
`endif
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the write-back cache core: a directed table walks
// the special cases, then a random stream of mostly well-formed requests of
// every kind over a small pool of sets and tags. Every result transfer is
// checked against a cycle-free model of the cache held in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import sawbc_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int RandItems   = 145;

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] va;
    logic [31:0] pa;
    logic [1:0]  sz;
    logic [31:0] wd;
    logic [5:0]  sn;
    logic [31:0] fd;
    logic        fe;
  } cache_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] data;
    logic [31:0] addr;
    logic [1:0]  size;
    logic        last;
  } cache_res_t;

  typedef struct {
    cache_req_t item;
    int         kind_typed; // -1 where the predictor decides alone
  } table_row_t;

  logic clk_i, rst_ni, start, busy;
  logic [2:0]  req_type_i;
  logic [31:0] virt_addr_i, phys_addr_i, write_data_i, fill_data_i;
  logic [1:0]  access_size_i;
  logic [5:0]  set_number_i;
  logic        fill_error_i;
  logic        result_valid_o, last_o;
  logic [2:0]  result_kind_o;
  logic [31:0] data_o, mem_addr_o;
  logic [1:0]  mem_size_o;

  set_assoc_writeback_cache_core uut (.*);

  // Shadow cache state
  logic [31:0]        words_m [Ways*Sets*WordsPerLine];
  logic [TagBits-1:0] tags_m  [Ways*Sets];
  logic               valid_m [Ways*Sets];
  logic               dirty_m [Ways*Sets];
  int                 victim_m;
  logic               fill_busy_m;
  int                 fill_cnt_m;
  cache_req_t         miss_req_m;

  cache_res_t expected_q[$];
  table_row_t stim_table[$];
  int errs = 0;
  int cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Enforce the run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int wslot(int way, int set);
    return way * Sets + set;
  endfunction

  function automatic void push_res(logic [2:0] k, logic [31:0] d, logic [31:0] a,
                                   logic [1:0] s);
    cache_res_t r;
    r.kind = k; r.data = d; r.addr = a; r.size = s; r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic int find_way(int set, logic [TagBits-1:0] tag);
    for (int w = 0; w < Ways; w++)
      if (valid_m[wslot(w, set)] && tags_m[wslot(w, set)] == tag) return w;
    return Ways;
  endfunction

  function automatic void write_back_set(int set);
    logic [31:0] base;
    for (int w = 0; w < Ways; w++) begin
      if (dirty_m[wslot(w, set)]) begin
        base = {tags_m[wslot(w, set)], 11'(set << OffsetBits)};
        for (int m = 0; m < WordsPerLine; m++)
          push_res(KindMemWrite, words_m[wslot(w, set)*WordsPerLine + m],
                   base + 32'(m*4), SizeWord);
        dirty_m[wslot(w, set)] = 1'b0;
      end
    end
  endfunction

  function automatic void answer_read(int way, int set, logic [31:0] va, logic [1:0] sz);
    logic [4:0]  offs;
    logic [31:0] wrd, v;
    offs = va[4:0];
    wrd  = words_m[wslot(way, set)*WordsPerLine + offs[4:2]];
    case (sz)
      SizeByte: v = (wrd >> (offs[1:0]*8)) & 32'hff;
      SizeHalf: v = (wrd >> (offs[1]*16)) & 32'hffff;
      SizeWord: v = wrd;
      default: begin
        push_res(KindError, 0, 0, 0);
        return;
      end
    endcase
    push_res(KindReadData, v, 0, 0);
    victim_m = (victim_m + 1) % Ways;
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic int predict_cache(cache_req_t it);
    int set, way, s, n0;
    logic [TagBits-1:0] tag;
    logic [31:0] mask, sd;
    n0  = expected_q.size();
    set = it.va[10:5];
    tag = it.pa[31:11];
    if (fill_busy_m && it.req != ReqFill) begin
      push_res(KindError, 0, 0, 0);
    end else begin
      case (it.req)
        ReqRead: begin
          way = find_way(set, tag);
          if (way < Ways) begin
            answer_read(way, set, it.va, it.sz);
          end else begin
            write_back_set(set);
            s = wslot(victim_m, set);
            valid_m[s] = 1'b0; dirty_m[s] = 1'b0; tags_m[s] = tag;
            miss_req_m = it; fill_busy_m = 1'b1; fill_cnt_m = 0;
            push_res(KindMemRead, 0, {it.pa[31:5], 5'd0}, SizeWord);
          end
        end
        ReqWrite: begin
          way = find_way(set, tag);
          if (it.sz == SizeBad) begin
            push_res(KindError, 0, 0, 0);
          end else if (way < Ways) begin
            s = wslot(way, set)*WordsPerLine + it.va[4:2];
            case (it.sz)
              SizeByte: begin
                mask = 32'hff << (it.va[1:0]*8); sd = it.wd << (it.va[1:0]*8);
              end
              SizeHalf: begin
                mask = 32'hffff << (it.va[1]*16); sd = it.wd << (it.va[1]*16);
              end
              default: begin
                mask = '1; sd = it.wd;
              end
            endcase
            words_m[s] = (words_m[s] & ~mask) | (sd & mask);
            dirty_m[wslot(way, set)] = 1'b1;
            victim_m = (victim_m + 1) % Ways;
            push_res(KindDone, 0, 0, 0);
          end else begin
            push_res(KindMemWrite, it.sz == SizeByte ? it.wd & 32'hff :
                     it.sz == SizeHalf ? it.wd & 32'hffff : it.wd, it.pa, it.sz);
          end
        end
        ReqFill: begin
          if (!fill_busy_m) begin
            push_res(KindError, 0, 0, 0);
          end else begin
            set = miss_req_m.va[10:5];
            s = wslot(victim_m, set);
            if (it.fe) begin
              valid_m[s] = 1'b0; dirty_m[s] = 1'b0;
              fill_busy_m = 1'b0; fill_cnt_m = 0;
              push_res(KindError, 0, 0, 0);
            end else begin
              words_m[s*WordsPerLine + fill_cnt_m] = it.fd;
              fill_cnt_m++;
              if (fill_cnt_m >= WordsPerLine) begin
                fill_busy_m = 1'b0; fill_cnt_m = 0;
                valid_m[s] = 1'b1; dirty_m[s] = 1'b0;
                answer_read(victim_m, set, miss_req_m.va, miss_req_m.sz);
              end else begin
                push_res(KindMemRead, 0,
                         {miss_req_m.pa[31:5], 5'd0} + 32'(fill_cnt_m*4), SizeWord);
              end
            end
          end
        end
        ReqFlush: begin
          write_back_set(it.sn);
          push_res(KindDone, 0, 0, 0);
        end
        ReqInvSet: begin
          for (int w = 0; w < Ways; w++) begin
            valid_m[wslot(w, it.sn)] = 1'b0; dirty_m[wslot(w, it.sn)] = 1'b0;
          end
          push_res(KindDone, 0, 0, 0);
        end
        ReqInvAll: begin
          foreach (valid_m[i]) begin
            valid_m[i] = 1'b0; dirty_m[i] = 1'b0;
          end
          push_res(KindDone, 0, 0, 0);
        end
        default: push_res(KindError, 0, 0, 0);
      endcase
    end
    expected_q[expected_q.size()-1].last = 1'b1;
    return expected_q.size() - n0;
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    cache_res_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d data %h", result_kind_o, data_o);
        errs++;
      end else begin
        e = expected_q.pop_front();
        if (result_kind_o !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, result_kind_o); errs++;
        end
        if (data_o !== e.data) begin
          $error("data exp %h got %h", e.data, data_o); errs++;
        end
        if (mem_addr_o !== e.addr) begin
          $error("mem_addr exp %h got %h", e.addr, mem_addr_o); errs++;
        end
        if (mem_size_o !== e.size) begin
          $error("mem_size exp %0d got %0d", e.size, mem_size_o); errs++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errs++;
        end
      end
    end
  end

  function automatic cache_req_t mk(logic [2:0] r, logic [31:0] va, logic [31:0] pa,
                                    logic [1:0] sz, logic [31:0] wd, logic [5:0] sn,
                                    logic [31:0] fd, logic fe);
    cache_req_t it;
    it.req = r; it.va = va; it.pa = pa; it.sz = sz;
    it.wd = wd; it.sn = sn; it.fd = fd; it.fe = fe;
    return it;
  endfunction

  function automatic void add_row(cache_req_t it, int k);
    table_row_t row;
    row.item = it; row.kind_typed = k;
    stim_table.push_back(row);
  endfunction

  // Random address inside a small pool so hits, evictions and write-backs occur
  function automatic void pool_addr(output logic [31:0] va, output logic [31:0] pa);
    logic [5:0] set;
    logic [20:0] tag;
    set = ($urandom_range(0, 9) == 0) ? 6'd63 : 6'($urandom_range(0, 2));
    case ($urandom_range(0, 2))
      0: tag = 21'h000000;
      1: tag = 21'h1fffff;
      default: tag = 21'h0a5a5a;
    endcase
    va = {21'($urandom_range(0, 2097151)), set, 5'($urandom_range(0, 31))};
    pa = {tag, 6'($urandom), va[4:0]};
  endfunction

  function automatic cache_req_t random_req();
    cache_req_t it;
    int pick;
    logic [31:0] va, pa;
    it = mk(3'($urandom), $urandom, $urandom, 2'($urandom), $urandom, 6'($urandom),
            $urandom, $urandom_range(0, 19) == 0);
    pool_addr(va, pa);
    it.va = va; it.pa = pa;
    it.sz = ($urandom_range(0, 19) == 0) ? SizeBad : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (fill_busy_m) begin
      it.req = (pick < 90) ? ReqFill : 3'($urandom_range(0, 7));
    end else if (pick < 40) begin
      it.req = ReqRead;
    end else if (pick < 70) begin
      it.req = ReqWrite;
    end else if (pick < 78) begin
      it.req = ReqFlush;
      if ($urandom_range(0, 3) != 0) it.sn = va[10:5];
    end else if (pick < 83) begin
      it.req = ReqInvSet;
      if ($urandom_range(0, 1) != 0) it.sn = va[10:5];
    end else if (pick < 85) begin
      it.req = ReqInvAll;
    end else if (pick < 88) begin
      it.req = ReqFill;
    end else if (pick < 90) begin
      it.req = 3'($urandom_range(6, 7));
    end else begin
      it.req = 3'($urandom_range(0, 7));
      it.va = $urandom; it.pa = $urandom;
    end
    return it;
  endfunction

  // Drive one request and hold it until the core takes it
  task automatic send_req(cache_req_t it, int kind_typed, bit allow_gap);
    int n;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= it.req; virt_addr_i <= it.va; phys_addr_i <= it.pa;
    access_size_i <= it.sz; write_data_i <= it.wd; set_number_i <= it.sn;
    fill_data_i <= it.fd; fill_error_i <= it.fe;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n = predict_cache(it);
    if (kind_typed >= 0 && (n != 1 || expected_q[expected_q.size()-1].kind != kind_typed)) begin
      $error("result_kind exp %0d got %0d", kind_typed, expected_q[expected_q.size()-1].kind);
      errs++;
    end
  endtask

  initial begin
    logic [31:0] va, pa, pb;
    start = 1'b0; req_type_i = '0; virt_addr_i = '0; phys_addr_i = '0;
    access_size_i = '0; write_data_i = '0; set_number_i = '0;
    fill_data_i = '0; fill_error_i = 1'b0;
    foreach (valid_m[i]) begin
      valid_m[i] = 1'b0; dirty_m[i] = 1'b0; tags_m[i] = '0;
    end
    foreach (words_m[i]) words_m[i] = '0;
    victim_m = 0; fill_busy_m = 1'b0; fill_cnt_m = 0; miss_req_m = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: controls, error codes, write misses, one full miss and fill
    va = 32'h0000_0040; pa = 32'h8000_0040; pb = 32'h4000_0840;
    add_row(mk(ReqInvAll, 0, 0, 0, 0, 0, 0, 0), KindDone);
    add_row(mk(ReqFill, 0, 0, 0, 0, 0, 32'hffffffff, 0), KindError);
    add_row(mk(3'd6, 0, 0, 0, 0, 0, 0, 0), KindError);
    add_row(mk(3'd7, '1, '1, '1, '1, '1, '1, 1), KindError);
    add_row(mk(ReqWrite, va, pa, SizeBad, '1, 0, 0, 0), KindError);
    add_row(mk(ReqWrite, '1, '1, SizeByte, '1, 0, 0, 0), -1);
    add_row(mk(ReqWrite, 0, 0, SizeHalf, '1, 0, 0, 0), -1);
    add_row(mk(ReqWrite, va, pa, SizeWord, 32'h1234_5678, 0, 0, 0), -1);
    add_row(mk(ReqFlush, 0, 0, 0, 0, 6'd63, 0, 0), KindDone);
    add_row(mk(ReqRead, va + 6, pa + 6, SizeHalf, 0, 0, 0, 0), -1);
    for (int i = 0; i < WordsPerLine - 1; i++)
      add_row(mk(ReqFill, 0, 0, 0, 0, 0, (i % 2) ? 32'h0 : 32'hffff_ffff - i, 0), -1);
    add_row(mk(ReqWrite, va, pa, SizeWord, 0, 0, 0, 0), KindError);
    add_row(mk(ReqFill, 0, 0, 0, 0, 0, 32'hcafe_f00d, 0), -1);
    add_row(mk(ReqWrite, va, pa, SizeWord, 32'hdead_beef, 0, 0, 0), KindDone);
    add_row(mk(ReqRead, va + 3, pa + 3, SizeByte, 0, 0, 0, 0), -1);
    add_row(mk(ReqRead, va, pa, SizeBad, 0, 0, 0, 0), KindError);
    add_row(mk(ReqFlush, 0, 0, 0, 0, 6'd2, 0, 0), -1);
    add_row(mk(ReqRead, pb, pb, SizeWord, 0, 0, 0, 0), -1);
    add_row(mk(ReqFill, 0, 0, 0, 0, 0, 0, 1), KindError);
    foreach (stim_table[i]) send_req(stim_table[i].item, stim_table[i].kind_typed, 1'b1);

    // Random stream, with no gaps towards the end
    for (int i = 0; i < RandItems; i++) send_req(random_req(), -1, i < RandItems - 30);
    start <= 1'b0;

    // Drain the result stream
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
